// File: design/hpid_pkg.sv
// Shared constants, widths and register indexes for the heater PID duty controller.
`timescale 1ns / 1ps

package hpid_pkg;

    // Field widths
    localparam int TEMP_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int ERR_W    = 17;
    localparam int DERIV_W  = 18;
    localparam int SUM_W    = 32;
    localparam int DUTY_W   = 7;
    localparam int THRESH_W = 18;

    // Product and accumulator widths (gains are zero-extended to signed)
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
    localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;
    localparam int ACC_W    = PROD_I_W + 2;
    localparam int ACC_SHIFT = 12;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INT_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TUNING     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_INC   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_QUIET_THR  = 3'd6;

    // Reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RESET = 16'd256;
    localparam logic [GAIN_W-1:0] GAIN_INC_RESET  = 16'd26;

    // Duty clamp limits in percent
    localparam logic [DUTY_W-1:0] DUTY_MIN = 7'd10;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    localparam int WINDOW_DEFAULT = 1024;

endpackage

// File: design/heater_pid_duty_controller_core.sv
// Top level of the heater PID duty controller: config registers, state update and pipeline.
`timescale 1ns / 1ps

// Heater PID duty controller.
// Input stream (s_axis_*): one temperature sample per transfer, 1/16 K, in tdata.
// Output stream (m_axis_*): one result per sample; tdata carries the duty in percent
// (10..100) and tuser carries the settled flag, which is set only in tuning mode once
// WINDOW consecutive derivatives have stayed at or below the quiet threshold.
// Configuration channel (cfg_*): register index and data, always ready; writes are
// expected while the block is idle. Writing the proportional gain loads the working
// gain that tuning mode ramps.
// Pipeline: input register, state update (error, derivative, saturating integral, gain
// ramp, quiet count), three gain multipliers, then sum and clamp into the output
// register. One sample is taken in every cycle while m_axis_tready does not hold the
// output; the integral and previous error are updated as the sample leaves the input
// register, which is what lets consecutive samples follow back to back.
// Each stage holds only while the stage after it is full and stalled, so the block keeps
// taking samples into empty stages while a result waits on m_axis_tready.
// Reset sets the configuration and state registers to their documented values and empties the pipeline.
module heater_pid_duty_controller_core
#(
    parameter int WINDOW = hpid_pkg::WINDOW_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [hpid_pkg::TEMP_W-1:0]          s_axis_tdata,  // [15:0] measured_temperature

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // [6:0] duty_percent, [7] zero
    output logic [0:0]                           m_axis_tuser,  // [0] settled

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hpid_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hpid_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int QCW = $clog2(WINDOW + 1);

    // Configuration registers
    logic        [hpid_pkg::TEMP_W-1:0]   target_reg;
    logic        [hpid_pkg::GAIN_W-1:0]   int_gain_reg;
    logic        [hpid_pkg::GAIN_W-1:0]   deriv_gain_reg;
    logic                                 tuning_reg;
    logic        [hpid_pkg::GAIN_W-1:0]   gain_inc_reg;
    logic signed [hpid_pkg::THRESH_W-1:0] quiet_thr_reg;

    // Controller state
    logic signed [hpid_pkg::SUM_W-1:0]    error_sum_reg,  error_sum_next;
    logic signed [hpid_pkg::ERR_W-1:0]    prev_err_reg;
    logic        [hpid_pkg::GAIN_W-1:0]   work_gain_reg,  work_gain_next;
    logic        [QCW-1:0]                quiet_cnt_reg,  quiet_cnt_next;

    // Pipeline stages
    logic                                 a_valid_reg;
    logic        [hpid_pkg::TEMP_W-1:0]   a_sample_reg;

    logic                                 b_valid_reg;
    logic signed [hpid_pkg::ERR_W-1:0]    b_err_reg;
    logic signed [hpid_pkg::DERIV_W-1:0]  b_deriv_reg;
    logic signed [hpid_pkg::SUM_W-1:0]    b_sum_reg;
    logic        [hpid_pkg::GAIN_W-1:0]   b_gain_reg;
    logic                                 b_settled_reg;

    logic                                 c_valid_reg;
    logic signed [hpid_pkg::PROD_P_W-1:0] c_prod_p_reg;
    logic signed [hpid_pkg::PROD_I_W-1:0] c_prod_i_reg;
    logic signed [hpid_pkg::PROD_D_W-1:0] c_prod_d_reg;
    logic                                 c_settled_reg;

    logic                                 out_valid_reg;
    logic        [hpid_pkg::DUTY_W-1:0]   out_duty_reg;
    logic                                 out_settled_reg;

    logic out_ready, c_ready, b_ready, a_ready;
    logic a_fire, b_fire, c_fire;
    logic cfg_fire;

    logic signed [hpid_pkg::ERR_W-1:0]    err;
    logic signed [hpid_pkg::DERIV_W-1:0]  deriv;
    logic signed [hpid_pkg::SUM_W:0]      sum_wide;
    logic        [hpid_pkg::GAIN_W:0]     gain_wide;
    logic                                 settled_next;
    logic        [hpid_pkg::DUTY_W-1:0]   duty;

    // Backpressure: a stage loads when it is empty or its content moves on.
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign c_ready       = !c_valid_reg || out_ready;
    assign b_ready       = !b_valid_reg || c_ready;
    assign a_ready       = !a_valid_reg || b_ready;
    assign s_axis_tready = a_ready;

    assign a_fire = a_valid_reg && b_ready;
    assign b_fire = b_valid_reg && c_ready;
    assign c_fire = c_valid_reg && out_ready;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // State update for the sample leaving the input register
    always_comb
    begin
        err   = $signed({1'b0, target_reg}) - $signed({1'b0, a_sample_reg});
        deriv = hpid_pkg::DERIV_W'(prev_err_reg) - hpid_pkg::DERIV_W'(err);

        gain_wide = {1'b0, work_gain_reg} + {1'b0, gain_inc_reg};
        if (!tuning_reg)
        begin
            work_gain_next = work_gain_reg;
        end
        else if (gain_wide[hpid_pkg::GAIN_W])
        begin
            work_gain_next = '1;
        end
        else
        begin
            work_gain_next = gain_wide[hpid_pkg::GAIN_W-1:0];
        end

        if (deriv <= quiet_thr_reg)
        begin
            if (quiet_cnt_reg < QCW'(WINDOW))
            begin
                quiet_cnt_next = quiet_cnt_reg + QCW'(1);
            end
            else
            begin
                quiet_cnt_next = quiet_cnt_reg;
            end
        end
        else
        begin
            quiet_cnt_next = '0;
        end

        // Saturate the integral: overflow shows as the two top bits differing.
        sum_wide = (hpid_pkg::SUM_W+1)'(error_sum_reg) + (hpid_pkg::SUM_W+1)'(err);
        if (sum_wide[hpid_pkg::SUM_W] != sum_wide[hpid_pkg::SUM_W-1])
        begin
            error_sum_next = sum_wide[hpid_pkg::SUM_W]
                           ? {1'b1, {(hpid_pkg::SUM_W-1){1'b0}}}
                           : {1'b0, {(hpid_pkg::SUM_W-1){1'b1}}};
        end
        else
        begin
            error_sum_next = sum_wide[hpid_pkg::SUM_W-1:0];
        end

        settled_next = tuning_reg && (quiet_cnt_next >= QCW'(WINDOW));
    end

    // Configuration registers and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            int_gain_reg   <= '0;
            deriv_gain_reg <= '0;
            tuning_reg     <= 1'b0;
            gain_inc_reg   <= hpid_pkg::GAIN_INC_RESET;
            quiet_thr_reg  <= '0;
            error_sum_reg  <= '0;
            prev_err_reg   <= '0;
            work_gain_reg  <= hpid_pkg::PROP_GAIN_RESET;
            quiet_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    hpid_pkg::REG_TARGET:     target_reg     <= cfg_data[hpid_pkg::TEMP_W-1:0];
                    hpid_pkg::REG_PROP_GAIN:  work_gain_reg  <= cfg_data[hpid_pkg::GAIN_W-1:0];
                    hpid_pkg::REG_INT_GAIN:   int_gain_reg   <= cfg_data[hpid_pkg::GAIN_W-1:0];
                    hpid_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg_data[hpid_pkg::GAIN_W-1:0];
                    hpid_pkg::REG_TUNING:     tuning_reg     <= cfg_data[0];
                    hpid_pkg::REG_GAIN_INC:   gain_inc_reg   <= cfg_data[hpid_pkg::GAIN_W-1:0];
                    hpid_pkg::REG_QUIET_THR:  quiet_thr_reg  <= $signed(cfg_data);
                    default: ;
                endcase
            end
            else if (a_fire)
            begin
                error_sum_reg <= error_sum_next;
                prev_err_reg  <= err;
                work_gain_reg <= work_gain_next;
                quiet_cnt_reg <= quiet_cnt_next;
            end
        end
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= s_axis_tvalid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && a_ready)
        begin
            a_sample_reg <= s_axis_tdata;
        end
        if (a_fire)
        begin
            b_err_reg     <= err;
            b_deriv_reg   <= deriv;
            b_sum_reg     <= error_sum_next;
            b_gain_reg    <= work_gain_next;
            b_settled_reg <= settled_next;
        end
        if (b_fire)
        begin
            c_prod_p_reg  <= $signed({1'b0, b_gain_reg}) * b_err_reg;
            c_prod_i_reg  <= $signed({1'b0, int_gain_reg}) * b_sum_reg;
            c_prod_d_reg  <= $signed({1'b0, deriv_gain_reg}) * b_deriv_reg;
            c_settled_reg <= b_settled_reg;
        end
        if (c_fire)
        begin
            out_duty_reg    <= duty;
            out_settled_reg <= c_settled_reg;
        end
    end

    hpid_duty u_duty
    (
        .prod_p (c_prod_p_reg),
        .prod_i (c_prod_i_reg),
        .prod_d (c_prod_d_reg),
        .duty   (duty)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_duty_reg};
    assign m_axis_tuser  = out_settled_reg;

endmodule

// File: design/hpid_duty.sv
// Sums the three PID terms, scales by the Q8.8 and 1/16 K shift, and clamps the duty.
`timescale 1ns / 1ps

module hpid_duty
(
    input  logic signed [hpid_pkg::PROD_P_W-1:0] prod_p,
    input  logic signed [hpid_pkg::PROD_I_W-1:0] prod_i,
    input  logic signed [hpid_pkg::PROD_D_W-1:0] prod_d,
    output logic        [hpid_pkg::DUTY_W-1:0]   duty
);

    localparam int QW = hpid_pkg::ACC_W - hpid_pkg::ACC_SHIFT;

    logic signed [hpid_pkg::ACC_W-1:0] acc;
    logic        [QW-2:0]              quot;

    assign acc = hpid_pkg::ACC_W'(prod_p) + hpid_pkg::ACC_W'(prod_i)
               + hpid_pkg::ACC_W'(prod_d);

    // Non-negative accumulator: the sign bit is zero, so the quotient is the bits below it.
    assign quot = acc[hpid_pkg::ACC_W-2:hpid_pkg::ACC_SHIFT];

    always_comb
    begin
        if (acc[hpid_pkg::ACC_W-1])
        begin
            duty = hpid_pkg::DUTY_MIN;
        end
        else if (quot > (QW-1)'(hpid_pkg::DUTY_MAX))
        begin
            duty = hpid_pkg::DUTY_MAX;
        end
        else if (quot < (QW-1)'(hpid_pkg::DUTY_MIN))
        begin
            duty = hpid_pkg::DUTY_MIN;
        end
        else
        begin
            duty = quot[hpid_pkg::DUTY_W-1:0];
        end
    end

endmodule
